/* rtl/mcer_pkg.sv */
// Shared types, register codes and reset values for the echo ranging block.
package mcer_pkg;

  localparam int unsigned CHANNELS_DEF   = 5;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned ECHO_PINS      = 5;
  localparam int unsigned WIDTH_BITS     = 16;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned CFG_IDX_BITS   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_START   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REST    = 2'd3;

  localparam logic [15:0] START_RST   = 16'd1;
  localparam logic [7:0]  TRIGGER_RST = 8'd4;
  localparam logic [7:0]  SAMPLE_RST  = 8'd15;
  localparam logic [15:0] REST_RST    = 16'd20000;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_TRIG   = 2'd1,
    PH_SAMPLE = 2'd2,
    PH_REST   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] start_ticks;
    logic [7:0]  trigger_ticks;
    logic [7:0]  sample_ticks;
    logic [15:0] rest_ticks;
  } cfg_t;

  typedef struct packed {
    logic sample_tick;
    logic publish;
  } seq_ctrl_t;

endpackage

/* rtl/mcer_seq.sv */
// Phase sequencer: interval timer, ranging phase and shared sample counter.
module mcer_seq #(
  parameter int unsigned COUNT_BITS = mcer_pkg::COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  mcer_pkg::cfg_t          cfg,
  input  logic                    all_done,
  output mcer_pkg::seq_ctrl_t     ctrl,
  output mcer_pkg::phase_t        phase,
  output logic [COUNT_BITS-1:0]   sample_count_next
);
  import mcer_pkg::*;

  phase_t                phase_next;
  logic [15:0]           wait_count;
  logic [15:0]           wait_count_next;
  logic [COUNT_BITS-1:0] sample_count;
  logic [15:0]           len;
  logic [15:0]           len_eff;
  logic [16:0]           tick_n;
  logic                  ends;

  // Interval timer shared by all phases
  always_comb begin
    unique case (phase)
      PH_START:  len = cfg.start_ticks;
      PH_TRIG:   len = {8'd0, cfg.trigger_ticks};
      PH_SAMPLE: len = {8'd0, cfg.sample_ticks};
      PH_REST:   len = cfg.rest_ticks;
      default:   len = cfg.rest_ticks;
    endcase
    len_eff         = (len == 16'd0) ? 16'd1 : len;
    tick_n          = {1'b0, wait_count} + 17'd1;
    ends            = (tick_n >= {1'b0, len_eff});
    wait_count_next = ends ? 16'd0 : tick_n[15:0];
  end

  assign sample_count_next = sample_count + 1'b1;

  // Next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_START:  if (ends) phase_next = PH_TRIG;
      PH_TRIG:   if (ends) phase_next = PH_SAMPLE;
      PH_SAMPLE: if (ends && all_done) phase_next = PH_REST;
      PH_REST:   if (ends) phase_next = PH_START;
      default:   phase_next = PH_START;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl = '0;
    unique case (phase)
      PH_SAMPLE: ctrl.sample_tick = ends;
      PH_REST:   ctrl.publish     = ends;
      default:   ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      wait_count   <= '0;
      sample_count <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      if (ctrl.sample_tick) begin
        sample_count <= all_done ? '0 : sample_count_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_on_all_done: assert property (@(posedge clk) disable iff (rst)
    advance && ctrl.sample_tick && all_done |=> sample_count == '0 && phase == PH_REST)
    else $error("sample counter not cleared on finishing the sampling phase");
`endif

endmodule

/* rtl/mcer_lane.sv */
// One ranging lane: rise stamp, done flag and measured echo width of a channel.
module mcer_lane #(
  parameter int unsigned COUNT_BITS = mcer_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  sample_tick,
  input  logic                  clear,
  input  logic                  echo,
  input  logic [COUNT_BITS-1:0] sample_count_next,
  output logic                  done_next,
  output logic [COUNT_BITS-1:0] width
);

  logic [COUNT_BITS-1:0] rise;
  logic                  done;
  logic                  rise_hit;
  logic                  fall_hit;

  // a zero stamp reads as not yet risen
  assign rise_hit  = sample_tick && !done && echo && (rise == '0);
  assign fall_hit  = sample_tick && !done && !echo && (rise != '0);
  assign done_next = done || fall_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise  <= '0;
      done  <= 1'b0;
      width <= '0;
    end else if (advance) begin
      if (clear) begin
        rise <= '0;
        done <= 1'b0;
      end else begin
        if (rise_hit) rise <= sample_count_next;
        if (fall_hit) done <= 1'b1;
      end
      if (fall_hit) width <= sample_count_next - rise;
    end
  end

`ifndef SYNTHESIS
  a_done_has_rise: assert property (@(posedge clk) disable iff (rst)
    done |-> rise != '0)
    else $error("channel marked done without a recorded rise");
`endif

endmodule

/* rtl/multi_channel_echo_ranging.sv */
// Top level of the multi-channel echo ranging timer.
//
//  channel  | signals                                       | dir | transfer when
//  ---------+-----------------------------------------------+-----+----------------------
//  in       | in_valid, in_ready, echo_levels               | in  | in_valid & in_ready
//  out      | out_valid, out_ready, trigger_level, publish, | out | out_valid & out_ready
//           | phase, width_ch0..width_ch4                   |     |
//  cfg      | cfg_we, cfg_index, cfg_data                   | in  | cfg_we
//
// Each input transfer is one base timer tick; the tick is applied in the cycle it
// is taken and its result sits in the output register from the next cycle on.
// One tick per clock is sustained while out_ready is high; the output register is
// the only stage, so a held result blocks the next tick (in_ready follows out_ready).
// Synchronous reset returns the block to the start wait phase with all counters,
// stamps, flags and published widths at zero and the registers at their defaults.
module multi_channel_echo_ranging #(
  parameter int unsigned CHANNELS   = mcer_pkg::CHANNELS_DEF,
  parameter int unsigned COUNT_BITS = mcer_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input ticks
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mcer_pkg::ECHO_PINS-1:0]      echo_levels,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                trigger_level,
  output logic                                publish,
  output logic [1:0]                          phase,
  output logic [mcer_pkg::WIDTH_BITS-1:0]     width_ch0,
  output logic [mcer_pkg::WIDTH_BITS-1:0]     width_ch1,
  output logic [mcer_pkg::WIDTH_BITS-1:0]     width_ch2,
  output logic [mcer_pkg::WIDTH_BITS-1:0]     width_ch3,
  output logic [mcer_pkg::WIDTH_BITS-1:0]     width_ch4,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [mcer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mcer_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mcer_pkg::*;

  cfg_t                  cfg;
  seq_ctrl_t             ctrl;
  phase_t                phase_st;
  logic                  advance;
  logic                  all_done;
  logic                  clear;
  logic [COUNT_BITS-1:0] sample_count_next;
  logic [CHANNELS-1:0]   lane_done_next;
  logic [COUNT_BITS-1:0] lane_width [CHANNELS];
  logic [WIDTH_BITS-1:0] published [ECHO_PINS];

  // Take a tick whenever the output register is free or being emptied
  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_ticks   <= START_RST;
      cfg.trigger_ticks <= TRIGGER_RST;
      cfg.sample_ticks  <= SAMPLE_RST;
      cfg.rest_ticks    <= REST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START:   cfg.start_ticks   <= cfg_data;
        CFG_TRIGGER: cfg.trigger_ticks <= cfg_data[7:0];
        CFG_SAMPLE:  cfg.sample_ticks  <= cfg_data[7:0];
        CFG_REST:    cfg.rest_ticks    <= cfg_data;
        default:     cfg.rest_ticks    <= cfg.rest_ticks;
      endcase
    end
  end

  mcer_seq #(
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .cfg              (cfg),
    .all_done         (all_done),
    .ctrl             (ctrl),
    .phase            (phase_st),
    .sample_count_next(sample_count_next)
  );

  // One lane per channel; channels beyond the echo pins see a low level
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    logic echo_bit;
    if (i < ECHO_PINS) begin : g_pin
      assign echo_bit = echo_levels[i];
    end else begin : g_nopin
      assign echo_bit = 1'b0;
    end

    mcer_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk              (clk),
      .rst              (rst),
      .advance          (advance),
      .sample_tick      (ctrl.sample_tick),
      .clear            (clear),
      .echo             (echo_bit),
      .sample_count_next(sample_count_next),
      .done_next        (lane_done_next[i]),
      .width            (lane_width[i])
    );
  end

  // Merge: the cycle finishes on the sample at which every lane is done
  assign all_done = &lane_done_next;
  assign clear    = ctrl.sample_tick && all_done;

  // Published widths: copy the low bits of each lane at the end of the rest
  for (genvar j = 0; j < ECHO_PINS; j++) begin : g_pub
    if (j < CHANNELS) begin : g_used
      logic [COUNT_BITS+WIDTH_BITS-1:0] ext;
      assign ext = {{WIDTH_BITS{1'b0}}, lane_width[j]};
      always_ff @(posedge clk) begin
        if (rst) begin
          published[j] <= '0;
        end else if (advance && ctrl.publish) begin
          published[j] <= ext[WIDTH_BITS-1:0];
        end
      end
    end else begin : g_unused
      always_ff @(posedge clk) begin
        if (rst) begin
          published[j] <= '0;
        end
      end
    end
  end

  // Output register: phase and widths are the state registers themselves,
  // which only move on a tick transfer, i.e. when this register reloads
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      publish   <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      publish   <= ctrl.publish;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign phase         = phase_st;
  assign trigger_level = (phase_st == PH_TRIG);
  assign width_ch0     = published[0];
  assign width_ch1     = published[1];
  assign width_ch2     = published[2];
  assign width_ch3     = published[3];
  assign width_ch4     = published[4];

`ifndef SYNTHESIS
  a_publish_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && publish |-> phase_st == PH_START)
    else $error("publish shown outside the start wait phase");

  a_publish_tick: assert property (@(posedge clk) disable iff (rst)
    advance && ctrl.publish |=> out_valid && publish)
    else $error("publishing tick not reflected in the result");

  a_clear_in_sample: assert property (@(posedge clk) disable iff (rst)
    clear |-> phase_st == PH_SAMPLE)
    else $error("lane clear outside the sampling phase");
`endif

endmodule
